// ----- sv/ppmd_pkg.sv -----
// Shared types, constants and codes for the PPM pulse train decoder.
`timescale 1ns / 1ps

package ppmd_pkg;

    // Number of channel slots in one frame (range 1 to 7).
    localparam int unsigned NUM_CHANNELS = 6;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned OFFSET_W = 10;
    localparam int unsigned VALUE_W  = 17;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned ROLL_W   = 2;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0]   SYNC_RESET   = 16'd3000;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd400;
    localparam logic [CNT_W-1:0]    CNT_MAX      = 4'd15;
    localparam logic [ROLL_W-1:0]   ROLL_MAX     = 2'd3;
    localparam logic [ROLL_W-1:0]   ROLL_LOST    = 2'd1;

    // Event codes carried on req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_RISE     = 2'd0,
        REQ_FALL     = 2'd1,
        REQ_ROLLOVER = 2'd2
    } ppmd_req_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_THRESHOLD = 1'b0,
        CFG_WIDTH_OFFSET   = 1'b1
    } ppmd_cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]   sync_threshold;
        logic [OFFSET_W-1:0] width_offset;
    } ppmd_cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIME_W-1:0] capture_time;
    } ppmd_event_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_written;
        logic [VALUE_W-1:0] slot_value;
        logic [TIME_W-1:0]  pulse_width;
        logic               sync_seen;
        logic               signal_lost;
    } ppmd_result_t;

endpackage

// ----- sv/ppmd_cfg_regs.sv -----
// Configuration registers of the PPM pulse train decoder.
`timescale 1ns / 1ps

module ppmd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ppmd_pkg::ppmd_cfg_t                 cfg
);

    ppmd_pkg::ppmd_cfg_t cfg_reg;
    ppmd_pkg::ppmd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ppmd_pkg::CFG_SYNC_THRESHOLD:
                begin
                    cfg_next.sync_threshold = cfg_data[ppmd_pkg::TIME_W-1:0];
                end
                ppmd_pkg::CFG_WIDTH_OFFSET:
                begin
                    cfg_next.width_offset = cfg_data[ppmd_pkg::OFFSET_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_threshold <= ppmd_pkg::SYNC_RESET;
            cfg_reg.width_offset   <= ppmd_pkg::OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/ppmd_in_stage.sv -----
// Input register that holds one capture event beat for the decode stage.
`timescale 1ns / 1ps

module ppmd_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ppmd_pkg::REQ_W-1:0]      req_type,
    input  logic [ppmd_pkg::TIME_W-1:0]     capture_time,
    input  logic                            take,
    output logic                            ev_valid,
    output ppmd_pkg::ppmd_event_t           ev
);

    logic                  valid_reg;
    logic                  valid_next;
    ppmd_pkg::ppmd_event_t ev_reg;
    logic                  load;

    // The register may refill in the same cycle that its beat moves on.
    assign in_ready   = !valid_reg || take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg.req_type     <= req_type;
            ev_reg.capture_time <= capture_time;
        end
    end

endmodule

// ----- sv/ppmd_decode.sv -----
// Decode state, width measurement and result register of the PPM decoder.
`timescale 1ns / 1ps

module ppmd_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ppmd_pkg::ppmd_cfg_t     cfg,
    input  logic                    ev_valid,
    input  ppmd_pkg::ppmd_event_t   ev,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ppmd_pkg::ppmd_result_t  result
);

    logic [ppmd_pkg::TIME_W-1:0] last_rise_reg;
    logic [ppmd_pkg::TIME_W-1:0] last_rise_next;
    logic [ppmd_pkg::CNT_W-1:0]  counter_reg;
    logic [ppmd_pkg::CNT_W-1:0]  counter_next;
    logic [ppmd_pkg::ROLL_W-1:0] rollover_reg;
    logic [ppmd_pkg::ROLL_W-1:0] rollover_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ppmd_pkg::ppmd_result_t      result_reg;
    ppmd_pkg::ppmd_result_t      result_next;

    logic [ppmd_pkg::TIME_W-1:0] diff;
    logic [ppmd_pkg::TIME_W-1:0] width;
    logic                        is_sync;
    logic                        slot_hit;

    // A beat moves on when the result register is empty or being emptied.
    assign take = ev_valid && (!out_valid_reg || out_ready);

    // A wrapped or equal capture measures against a period of 0xFFFF,
    // which is the plain difference less one.
    assign diff    = ev.capture_time - last_rise_reg;
    assign width   = (ev.capture_time > last_rise_reg) ? diff : diff - 16'd1;
    assign is_sync = width > cfg.sync_threshold;

    always_comb
    begin
        last_rise_next = last_rise_reg;
        counter_next   = counter_reg;
        rollover_next  = rollover_reg;
        result_next    = '0;
        slot_hit       = 1'b0;

        unique case (ev.req_type)
            ppmd_pkg::REQ_RISE:
            begin
                last_rise_next = ev.capture_time;
                rollover_next  = '0;
            end
            ppmd_pkg::REQ_FALL:
            begin
                result_next.pulse_width = width;
                if (is_sync)
                begin
                    result_next.sync_seen = 1'b1;
                    counter_next          = '0;
                end
                else if (counter_reg != ppmd_pkg::CNT_MAX)
                begin
                    counter_next = counter_reg + 4'd1;
                end
                slot_hit = (counter_next != '0) &&
                           (counter_next <= ppmd_pkg::CNT_W'(ppmd_pkg::NUM_CHANNELS));
                if (slot_hit)
                begin
                    result_next.slot_written = counter_next[ppmd_pkg::SLOT_W-1:0];
                    result_next.slot_value   = {1'b0, width} +
                                               ppmd_pkg::VALUE_W'(cfg.width_offset);
                end
            end
            ppmd_pkg::REQ_ROLLOVER:
            begin
                if (rollover_reg != ppmd_pkg::ROLL_MAX)
                begin
                    rollover_next = rollover_reg + 2'd1;
                end
            end
            default:
            begin
                rollover_next = rollover_reg;
            end
        endcase

        result_next.signal_lost = rollover_next > ppmd_pkg::ROLL_LOST;
    end

    assign out_valid_next = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rise_reg <= '0;
            counter_reg   <= '0;
            rollover_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                last_rise_reg <= last_rise_next;
                counter_reg   <= counter_next;
                rollover_reg  <= rollover_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- sv/ppm_pulse_train_decoder.sv -----
// Top level of the PPM pulse train decoder.
`timescale 1ns / 1ps

// The decoder turns timer capture events of an RC PPM pulse train into
// channel values. Each input beat carries req_type (rising capture, falling
// capture or timer rollover tick) and capture_time. Each accepted beat gives
// exactly one result beat: the channel slot written (0 for none), the value
// stored in it (measured width plus width_offset), the measured pulse width,
// a sync flag and the signal-lost flag. The decoded channel table itself is
// kept by the receiver from the slot_written and slot_value fields.
// Both channels use valid/ready. A beat goes into an input register, then
// the decode logic updates the frame state and loads the result register.
// One beat is taken in every cycle while the receiver takes results; the
// single decode pass between the two registers sets that rate. When the
// receiver stalls, the result register holds and the input register
// still takes one more beat, after which in_ready falls until the
// result is taken.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// sync_threshold (index 0) and width_offset (index 1); it is always ready
// and should be written only while the decoder is idle. Reset restores
// sync_threshold to 3000 and width_offset to 400, clears the last rise
// time, channel counter and rollover count, and empties both registers.

module ppm_pulse_train_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ppmd_pkg::REQ_W-1:0]          req_type,
    input  logic [ppmd_pkg::TIME_W-1:0]         capture_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppmd_pkg::SLOT_W-1:0]         slot_written,
    output logic [ppmd_pkg::VALUE_W-1:0]        slot_value,
    output logic [ppmd_pkg::TIME_W-1:0]         pulse_width,
    output logic                                sync_seen,
    output logic                                signal_lost,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ppmd_pkg::ppmd_cfg_t    cfg;
    ppmd_pkg::ppmd_event_t  ev;
    ppmd_pkg::ppmd_result_t result;
    logic                   ev_valid;
    logic                   take;

    // Register file for the two set-up values.
    ppmd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: holds one event beat until the decode stage takes it.
    ppmd_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .capture_time (capture_time),
        .take         (take),
        .ev_valid     (ev_valid),
        .ev           (ev)
    );

    // Width measurement, frame state and the result register.
    ppmd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign slot_written = result.slot_written;
    assign slot_value   = result.slot_value;
    assign pulse_width  = result.pulse_width;
    assign sync_seen    = result.sync_seen;
    assign signal_lost  = result.signal_lost;

    // A sync gap restarts the frame, so it never writes a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sync_seen) |-> (slot_written == '0))
        else $error("sync gap reported together with a slot write");

    // A written slot holds the reported width plus the configured offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (slot_written != '0)) |->
            (slot_value == ({1'b0, pulse_width} +
                            ppmd_pkg::VALUE_W'(cfg.width_offset))))
        else $error("slot value does not match width plus offset");

    // An empty input register always accepts a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ev_valid |-> in_ready)
        else $error("input refused while the input register is empty");

    // A beat taken by the decode stage shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("decoded beat did not reach the result register");

endmodule
